// File: src/mclgw_pkg.sv
package mclgw_pkg;

  // Fixed field widths
  localparam int PAGE_W  = 24;
  localparam int LIM_W   = 7;
  localparam int GS_W    = 13;
  localparam int OCC_W   = 7;
  localparam int CFG_W   = 13;
  localparam int DCNT_W  = $clog2(PAGE_W);

  // Command codes
  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_EVICT  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_LIMIT = 1'b0;
  localparam logic CFG_GROUP = 1'b1;

  // Configuration reset values
  localparam logic [LIM_W-1:0] LIMIT_RST = 7'd64;
  localparam logic [GS_W-1:0]  GROUP_RST = 13'd1024;

  typedef struct packed {
    logic              command;
    logic [PAGE_W-1:0] lpn;
    logic              is_write;
  } in_req_t;

  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [PAGE_W-1:0] evicted_lpn;
    logic              writeback;
    logic [PAGE_W-1:0] written_group;
    logic [OCC_W-1:0]  occupancy;
  } out_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_EVICT,
    S_DIV,
    S_RM,
    S_NEXT,
    S_TOUCH,
    S_INS,
    S_INS_WR,
    S_OUT
  } st_t;

endpackage

// File: src/mapping_cache_lru_group_writeback_top.sv
// A hit and a miss each take a lookup sweep and an update sweep; each eviction adds
// a removal sweep, plus the group divide when the evicted entry is dirty.
// Throughput: one request at a time, the next accepted the cycle after the result is
// registered; every sweep phase covers the full entry RAM, one entry per cycle.
// Reset: synchronous active-low rst_n clears control, configuration, count and valid bits;
// entry contents are left as they are, so no clearing pass is needed.
module mapping_cache_lru_group_writeback_top
  import mclgw_pkg::*;
#(
  parameter int CACHE_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_req_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_rsp_t         out_data,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int IW    = $clog2(CACHE_DEPTH);
  localparam int RW    = IW;
  localparam int CNT_W = $clog2(CACHE_DEPTH + 1);
  localparam int CW    = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int MW    = PAGE_W + 1 + RW;

  // Configuration
  logic [LIM_W-1:0] lim_r;
  logic [GS_W-1:0]  gsz_r;

  // Control and sweep state
  st_t              state_r, state_nxt;
  in_req_t          req_r, req_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] sw_r, sw_nxt;
  logic [CACHE_DEPTH-1:0] vld_r, vld_nxt;

  // Lookup match
  logic             mfound_r, mfound_nxt;
  logic [IW-1:0]    midx_r, midx_nxt;
  logic [RW-1:0]    mrank_r, mrank_nxt;
  logic             mdirty_r, mdirty_nxt;

  // Current LRU victim
  logic [IW-1:0]     vidx_r, vidx_nxt;
  logic [PAGE_W-1:0] vpage_r, vpage_nxt;
  logic              vdirty_r, vdirty_nxt;

  // Removal target
  logic [IW-1:0]     tidx_r, tidx_nxt;
  logic [RW-1:0]     trank_r, trank_nxt;
  logic [PAGE_W-1:0] tpage_r, tpage_nxt;
  logic              tdirty_r, tdirty_nxt;
  logic              clean_r, clean_nxt;

  // Free slot for insert
  logic          ffound_r, ffound_nxt;
  logic [IW-1:0] fidx_r, fidx_nxt;

  // Group-size divider
  logic [PAGE_W-1:0] dq_r, dq_nxt;
  logic [GS_W-1:0]   drem_r, drem_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;

  // Result accumulation and output register
  logic              rhit_r, rhit_nxt;
  logic              rev_r, rev_nxt;
  logic [PAGE_W-1:0] revp_r, revp_nxt;
  logic              rwb_r, rwb_nxt;
  logic [PAGE_W-1:0] rgrp_r, rgrp_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_rsp_t          out_data_r, out_data_nxt;

  // Entry RAM: {page, dirty, rank}
  logic [MW-1:0] mem [CACHE_DEPTH];
  logic [MW-1:0] mem_q;
  logic          mem_we;
  logic [IW-1:0] mem_wa;
  logic [MW-1:0] mem_wd;
  logic [IW-1:0] rd_addr;

  // Derived values
  logic [GS_W-1:0]   gs_eff;
  logic [CW-1:0]     lim_ext, lim_eff;
  logic              full;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2, sw_m1;
  logic              sw_last, p_act;
  logic [IW-1:0]     p_idx;
  logic [PAGE_W-1:0] e_page;
  logic              e_dirty;
  logic [RW-1:0]     e_rank;
  logic              e_vld;
  logic [PAGE_W-1:0] grp_lo;
  logic [PAGE_W:0]   grp_diff;
  logic              in_grp;
  logic [GS_W:0]     div_t;
  logic              div_ge;
  logic [RW-1:0]     new_rank;
  logic              new_dirty;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= LIMIT_RST;
      gsz_r <= GROUP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_LIMIT: lim_r <= cfg_wdata[LIM_W-1:0];
        CFG_GROUP: gsz_r <= cfg_wdata[GS_W-1:0];
      endcase
    end
  end

  // Clamp limit and group size
  assign gs_eff  = (gsz_r == '0) ? GS_W'(1) : gsz_r;
  assign lim_ext = CW'(lim_r);
  assign lim_eff = (lim_r == '0) ? CW'(1) :
                   (lim_ext > CW'(CACHE_DEPTH)) ? CW'(CACHE_DEPTH) : lim_ext;
  assign full    = CW'(cnt_r) >= lim_eff;
  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign cnt_m2  = cnt_r - CNT_W'(2);

  // Sweep pipeline: read entry sw, process entry sw-1
  assign sw_last = sw_r == CNT_W'(CACHE_DEPTH);
  assign sw_m1   = sw_r - CNT_W'(1);
  assign p_act   = sw_r != '0;
  assign p_idx   = sw_m1[IW-1:0];
  assign rd_addr = sw_last ? '0 : sw_r[IW-1:0];
  assign e_page  = mem_q[MW-1 -: PAGE_W];
  assign e_dirty = mem_q[RW];
  assign e_rank  = mem_q[RW-1:0];
  assign e_vld   = vld_r[p_idx];

  // Group membership: lo = page - page % gs, member when 0 <= p - lo < gs
  assign grp_lo   = tpage_r - PAGE_W'(drem_r);
  assign grp_diff = {1'b0, e_page} - {1'b0, grp_lo};
  assign in_grp   = !grp_diff[PAGE_W] && (grp_diff[PAGE_W-1:0] < PAGE_W'(gs_eff));

  // One restoring divide step
  assign div_t  = {drem_r, dq_r[PAGE_W-1]};
  assign div_ge = div_t >= {1'b0, gs_eff};

  // Rank and dirty after removal of the target
  assign new_rank  = (e_rank > trank_r) ? e_rank - RW'(1) : e_rank;
  assign new_dirty = (clean_r && in_grp) ? 1'b0 : e_dirty;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    sw_nxt        = sw_r;
    vld_nxt       = vld_r;
    mfound_nxt    = mfound_r;
    midx_nxt      = midx_r;
    mrank_nxt     = mrank_r;
    mdirty_nxt    = mdirty_r;
    vidx_nxt      = vidx_r;
    vpage_nxt     = vpage_r;
    vdirty_nxt    = vdirty_r;
    tidx_nxt      = tidx_r;
    trank_nxt     = trank_r;
    tpage_nxt     = tpage_r;
    tdirty_nxt    = tdirty_r;
    clean_nxt     = clean_r;
    ffound_nxt    = ffound_r;
    fidx_nxt      = fidx_r;
    dq_nxt        = dq_r;
    drem_nxt      = drem_r;
    dcnt_nxt      = dcnt_r;
    rhit_nxt      = rhit_r;
    rev_nxt       = rev_r;
    revp_nxt      = revp_r;
    rwb_nxt       = rwb_r;
    rgrp_nxt      = rgrp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = p_idx;
    mem_wd        = mem_q;
    in_ready      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_nxt    = in_data;
          sw_nxt     = '0;
          mfound_nxt = 1'b0;
          rhit_nxt   = 1'b0;
          rev_nxt    = 1'b0;
          revp_nxt   = '0;
          rwb_nxt    = 1'b0;
          rgrp_nxt   = '0;
          state_nxt  = S_LOOK;
        end
      end

      // Find the page and the LRU entry
      S_LOOK: begin
        sw_nxt = sw_r + CNT_W'(1);
        if (p_act && e_vld) begin
          if (e_page == req_r.lpn) begin
            mfound_nxt = 1'b1;
            midx_nxt   = p_idx;
            mrank_nxt  = e_rank;
            mdirty_nxt = e_dirty;
          end
          if (e_rank == cnt_m1[RW-1:0]) begin
            vidx_nxt   = p_idx;
            vpage_nxt  = e_page;
            vdirty_nxt = e_dirty;
          end
        end
        if (sw_last) begin
          sw_nxt = '0;
          if (req_r.command == CMD_EVICT) begin
            if (mfound_nxt) begin
              rhit_nxt   = 1'b1;
              tidx_nxt   = midx_nxt;
              trank_nxt  = mrank_nxt;
              tpage_nxt  = req_r.lpn;
              tdirty_nxt = mdirty_nxt;
              state_nxt  = S_EVICT;
            end else begin
              state_nxt = S_OUT;
            end
          end else if (mfound_nxt) begin
            rhit_nxt  = 1'b1;
            state_nxt = S_TOUCH;
          end else begin
            state_nxt = S_NEXT;
          end
        end
      end

      // Start removal of the target
      S_EVICT: begin
        rev_nxt  = 1'b1;
        revp_nxt = tpage_r;
        sw_nxt   = '0;
        dq_nxt   = tpage_r;
        drem_nxt = '0;
        dcnt_nxt = '0;
        if (tdirty_r) begin
          state_nxt = S_DIV;
        end else begin
          clean_nxt = 1'b0;
          state_nxt = S_RM;
        end
      end

      // Divide target page by group size, one bit a cycle
      S_DIV: begin
        dq_nxt   = {dq_r[PAGE_W-2:0], div_ge};
        drem_nxt = div_ge ? GS_W'(div_t - {1'b0, gs_eff}) : div_t[GS_W-1:0];
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(PAGE_W - 1)) begin
          clean_nxt = 1'b1;
          rwb_nxt   = 1'b1;
          rgrp_nxt  = dq_nxt;
          state_nxt = S_RM;
        end
      end

      // Drop target, close rank gap, clean its group, find next LRU
      S_RM: begin
        sw_nxt = sw_r + CNT_W'(1);
        if (p_act) begin
          if (p_idx == tidx_r) begin
            vld_nxt[p_idx] = 1'b0;
          end else if (e_vld) begin
            mem_we = 1'b1;
            mem_wd = {e_page, new_dirty, new_rank};
            if (new_rank == cnt_m2[RW-1:0]) begin
              vidx_nxt   = p_idx;
              vpage_nxt  = e_page;
              vdirty_nxt = new_dirty;
            end
          end
        end
        if (sw_last) begin
          sw_nxt    = '0;
          cnt_nxt   = cnt_m1;
          state_nxt = S_NEXT;
        end
      end

      // Evict command ends here; otherwise evict again while full, else insert
      S_NEXT: begin
        sw_nxt = '0;
        if (req_r.command == CMD_EVICT) begin
          state_nxt = S_OUT;
        end else if (full) begin
          tidx_nxt   = vidx_r;
          trank_nxt  = cnt_m1[RW-1:0];
          tpage_nxt  = vpage_r;
          tdirty_nxt = vdirty_r;
          state_nxt  = S_EVICT;
        end else begin
          ffound_nxt = 1'b0;
          state_nxt  = S_INS;
        end
      end

      // Move hit entry to the front
      S_TOUCH: begin
        sw_nxt = sw_r + CNT_W'(1);
        if (p_act && e_vld) begin
          if (p_idx == midx_r) begin
            mem_we = 1'b1;
            mem_wd = {e_page, e_dirty | req_r.is_write, RW'(0)};
          end else if (e_rank < mrank_r) begin
            mem_we = 1'b1;
            mem_wd = {e_page, e_dirty, e_rank + RW'(1)};
          end
        end
        if (sw_last) begin
          sw_nxt    = '0;
          state_nxt = S_OUT;
        end
      end

      // Age every valid entry and pick the first free slot
      S_INS: begin
        sw_nxt = sw_r + CNT_W'(1);
        if (p_act) begin
          if (e_vld) begin
            mem_we = 1'b1;
            mem_wd = {e_page, e_dirty, e_rank + RW'(1)};
          end else if (!ffound_r) begin
            ffound_nxt = 1'b1;
            fidx_nxt   = p_idx;
          end
        end
        if (sw_last) begin
          sw_nxt    = '0;
          state_nxt = S_INS_WR;
        end
      end

      // Write the new entry as most recently used
      S_INS_WR: begin
        if (ffound_r) begin
          mem_we          = 1'b1;
          mem_wa          = fidx_r;
          mem_wd          = {req_r.lpn, req_r.is_write, RW'(0)};
          vld_nxt[fidx_r] = 1'b1;
          cnt_nxt         = cnt_r + CNT_W'(1);
        end
        state_nxt = S_OUT;
      end

      // Hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.hit           = rhit_r;
          out_data_nxt.evicted       = rev_r;
          out_data_nxt.evicted_lpn   = revp_r;
          out_data_nxt.writeback     = rwb_r;
          out_data_nxt.written_group = rgrp_r;
          out_data_nxt.occupancy     = OCC_W'(cnt_r);
          state_nxt                  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sw_r        <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sw_r        <= sw_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    mfound_r   <= mfound_nxt;
    midx_r     <= midx_nxt;
    mrank_r    <= mrank_nxt;
    mdirty_r   <= mdirty_nxt;
    vidx_r     <= vidx_nxt;
    vpage_r    <= vpage_nxt;
    vdirty_r   <= vdirty_nxt;
    tidx_r     <= tidx_nxt;
    trank_r    <= trank_nxt;
    tpage_r    <= tpage_nxt;
    tdirty_r   <= tdirty_nxt;
    clean_r    <= clean_nxt;
    ffound_r   <= ffound_nxt;
    fidx_r     <= fidx_nxt;
    dq_r       <= dq_nxt;
    drem_r     <= drem_nxt;
    dcnt_r     <= dcnt_nxt;
    rhit_r     <= rhit_nxt;
    rev_r      <= rev_nxt;
    revp_r     <= revp_nxt;
    rwb_r      <= rwb_nxt;
    rgrp_r     <= rgrp_nxt;
    out_data_r <= out_data_nxt;
  end

  // Entry RAM
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Occupancy never exceeds the entry count
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CACHE_DEPTH))
    else $error("entry count above depth");

  // Between requests the count matches the valid bits
  a_cnt_vld: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(vld_r) == int'(cnt_r)))
    else $error("entry count out of step with valid bits");

  // An accepted request starts a lookup sweep
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_LOOK && sw_r == '0))
    else $error("request did not start lookup");

  // A writeback only comes with an eviction
  a_wb_ev: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.writeback || out_data_r.evicted))
    else $error("writeback without eviction");

  // Divider only runs for a dirty target
  a_div_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> tdirty_r)
    else $error("group divide for clean target");

endmodule
